### sv/swd_hte_pkg.sv
// Shared types and constants for the serial wire debug host transaction engine.
// Depends on nothing; every other file refers to it by scoped names.
package swd_hte_pkg;

  // Sequence lengths, in clock pulses.
  localparam int unsigned RESET_HIGH_CLOCKS  = 60;
  localparam int unsigned RESET_LOW_CLOCKS   = 3;
  localparam int unsigned READ_TRAIL_CLOCKS  = 3;
  localparam int unsigned WRITE_TRAIL_CLOCKS = 20;
  localparam int unsigned HEADER_BITS        = 8;
  localparam int unsigned ACK_BITS           = 3;
  localparam int unsigned DATA_PAR_BITS      = 33;

  localparam int unsigned COUNT_W = 7;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned SHIFT_W = 33;
  localparam int unsigned ACK_W   = 3;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_RESET = 2'd2,
    KIND_TICK  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_HDR    = 4'd1,
    PH_TURN1  = 4'd2,
    PH_ACK    = 4'd3,
    PH_RDATA  = 4'd4,
    PH_RTRAIL = 4'd5,
    PH_TURN2  = 4'd6,
    PH_WDATA  = 4'd7,
    PH_WTRAIL = 4'd8,
    PH_RHIGH  = 4'd9,
    PH_RLOW   = 4'd10
  } phase_e;

  // One result item.
  typedef struct packed {
    logic               drive_enable;
    logic               drive_level;
    logic               clock_pulse;
    logic               busy_res;
    logic               done_res;
    logic [ACK_W-1:0]   ack;
    logic [WORD_W-1:0]  read_data;
    logic               read_parity;
  } result_t;

  // Request header, sent LSB first: start, APnDP, RnW, A2, A3, parity, stop, park.
  function automatic logic [HEADER_BITS-1:0] make_header(logic rd, logic ap,
                                                          logic [1:0] addr);
    logic par;
    par = ap ^ rd ^ addr[0] ^ addr[1];
    return {1'b1, 1'b0, par, addr[1], addr[0], rd, ap, 1'b1};
  endfunction

endpackage

### sv/swd_hte_core.sv
// Transaction sequencer: phase state machine, bit counter and shift registers.
// Depends on swd_hte_pkg. Advances once per accepted item and forms its result.
module swd_hte_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fire_i,
  input  logic [1:0]               kind_i,
  input  logic                     ap_sel_i,
  input  logic [1:0]               reg_addr_i,
  input  logic [31:0]              write_data_i,
  input  logic                     line_in_i,
  output swd_hte_pkg::result_t     res_o
);

  swd_hte_pkg::phase_e phase_q, phase_d;
  logic [swd_hte_pkg::COUNT_W-1:0] count_q, count_d, count_inc;
  logic                            is_write_q, is_write_d;
  logic [swd_hte_pkg::SHIFT_W-1:0] out_shift_q, out_shift_d;
  logic [swd_hte_pkg::SHIFT_W-1:0] in_shift_q, in_shift_d;
  logic [swd_hte_pkg::ACK_W-1:0]   ack_q, ack_d;
  logic [swd_hte_pkg::WORD_W-1:0]  data_q, data_d;
  logic                            parity_q, parity_d;
  logic                            de, lvl, clk_pulse, done;
  logic [swd_hte_pkg::SHIFT_W-1:0] rdata_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= swd_hte_pkg::PH_IDLE;
      count_q     <= '0;
      is_write_q  <= 1'b0;
      out_shift_q <= '0;
      in_shift_q  <= '0;
      ack_q       <= '0;
      data_q      <= '0;
      parity_q    <= 1'b0;
    end else if (fire_i) begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      is_write_q  <= is_write_d;
      out_shift_q <= out_shift_d;
      in_shift_q  <= in_shift_d;
      ack_q       <= ack_d;
      data_q      <= data_d;
      parity_q    <= parity_d;
    end
  end

  assign count_inc  = count_q + swd_hte_pkg::COUNT_W'(1);
  // Read bits arrive LSB first; after all bits the first one sits in bit 0.
  assign rdata_next = {line_in_i, in_shift_q[swd_hte_pkg::SHIFT_W-1:1]};

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    is_write_d  = is_write_q;
    out_shift_d = out_shift_q;
    in_shift_d  = in_shift_q;
    ack_d       = ack_q;
    data_d      = data_q;
    parity_d    = parity_q;
    de          = 1'b1;
    lvl         = 1'b0;
    clk_pulse   = 1'b0;
    done        = 1'b0;

    if (kind_i != swd_hte_pkg::KIND_TICK) begin
      // Commands are honored only when idle.
      if (phase_q == swd_hte_pkg::PH_IDLE) begin
        count_d = '0;
        if (kind_i == swd_hte_pkg::KIND_RESET) begin
          phase_d = swd_hte_pkg::PH_RHIGH;
        end else begin
          is_write_d  = (kind_i == swd_hte_pkg::KIND_WRITE);
          out_shift_d = swd_hte_pkg::SHIFT_W'(swd_hte_pkg::make_header(
                          kind_i != swd_hte_pkg::KIND_WRITE, ap_sel_i, reg_addr_i));
          ack_d       = '0;
          phase_d     = swd_hte_pkg::PH_HDR;
          in_shift_d  = swd_hte_pkg::SHIFT_W'(write_data_i);
        end
      end
    end else if (phase_q != swd_hte_pkg::PH_IDLE) begin
      clk_pulse = 1'b1;
      case (phase_q)
        swd_hte_pkg::PH_HDR: begin
          lvl         = out_shift_q[0];
          out_shift_d = out_shift_q >> 1;
          count_d     = count_inc;
          if (count_inc >= swd_hte_pkg::COUNT_W'(swd_hte_pkg::HEADER_BITS)) begin
            phase_d = swd_hte_pkg::PH_TURN1;
            count_d = '0;
          end
        end
        swd_hte_pkg::PH_TURN1: begin
          de      = 1'b0;
          phase_d = swd_hte_pkg::PH_ACK;
          count_d = '0;
        end
        swd_hte_pkg::PH_ACK: begin
          de      = 1'b0;
          ack_d   = ack_q | (swd_hte_pkg::ACK_W'(line_in_i) << count_q[1:0]);
          count_d = count_inc;
          if (count_inc >= swd_hte_pkg::COUNT_W'(swd_hte_pkg::ACK_BITS)) begin
            count_d = '0;
            if (is_write_q) begin
              phase_d = swd_hte_pkg::PH_TURN2;
            end else begin
              in_shift_d = '0;
              phase_d    = swd_hte_pkg::PH_RDATA;
            end
          end
        end
        swd_hte_pkg::PH_RDATA: begin
          de         = 1'b0;
          in_shift_d = rdata_next;
          count_d    = count_inc;
          if (count_inc >= swd_hte_pkg::COUNT_W'(swd_hte_pkg::DATA_PAR_BITS)) begin
            data_d   = rdata_next[swd_hte_pkg::WORD_W-1:0];
            parity_d = rdata_next[swd_hte_pkg::SHIFT_W-1];
            phase_d  = swd_hte_pkg::PH_RTRAIL;
            count_d  = '0;
          end
        end
        swd_hte_pkg::PH_RTRAIL: begin
          count_d = count_inc;
          if (count_inc >= swd_hte_pkg::COUNT_W'(swd_hte_pkg::READ_TRAIL_CLOCKS)) begin
            phase_d = swd_hte_pkg::PH_IDLE;
            count_d = '0;
            done    = 1'b1;
          end
        end
        swd_hte_pkg::PH_TURN2: begin
          de          = 1'b0;
          out_shift_d = {^in_shift_q[swd_hte_pkg::WORD_W-1:0],
                         in_shift_q[swd_hte_pkg::WORD_W-1:0]};
          phase_d     = swd_hte_pkg::PH_WDATA;
          count_d     = '0;
        end
        swd_hte_pkg::PH_WDATA: begin
          lvl         = out_shift_q[0];
          out_shift_d = out_shift_q >> 1;
          count_d     = count_inc;
          if (count_inc >= swd_hte_pkg::COUNT_W'(swd_hte_pkg::DATA_PAR_BITS)) begin
            phase_d = swd_hte_pkg::PH_WTRAIL;
            count_d = '0;
          end
        end
        swd_hte_pkg::PH_WTRAIL: begin
          count_d = count_inc;
          if (count_inc >= swd_hte_pkg::COUNT_W'(swd_hte_pkg::WRITE_TRAIL_CLOCKS)) begin
            phase_d = swd_hte_pkg::PH_IDLE;
            count_d = '0;
            done    = 1'b1;
          end
        end
        swd_hte_pkg::PH_RHIGH: begin
          lvl     = 1'b1;
          count_d = count_inc;
          if (count_inc >= swd_hte_pkg::COUNT_W'(swd_hte_pkg::RESET_HIGH_CLOCKS)) begin
            phase_d = swd_hte_pkg::PH_RLOW;
            count_d = '0;
          end
        end
        swd_hte_pkg::PH_RLOW: begin
          count_d = count_inc;
          if (count_inc >= swd_hte_pkg::COUNT_W'(swd_hte_pkg::RESET_LOW_CLOCKS)) begin
            phase_d = swd_hte_pkg::PH_IDLE;
            count_d = '0;
            done    = 1'b1;
          end
        end
        default: begin
          // Undefined phase codes fall back to idle without a pulse.
          clk_pulse = 1'b0;
          phase_d   = swd_hte_pkg::PH_IDLE;
          count_d   = '0;
        end
      endcase
    end

    res_o.drive_enable = de;
    res_o.drive_level  = de & lvl;
    res_o.clock_pulse  = clk_pulse;
    res_o.busy_res     = (phase_d != swd_hte_pkg::PH_IDLE);
    res_o.done_res     = done;
    res_o.ack          = ack_d;
    res_o.read_data    = data_d;
    res_o.read_parity  = parity_d;
  end

endmodule

### sv/swd_hte_out_stage.sv
// Result register with valid flag; while it is full, an output stall holds the input side.
// Depends on swd_hte_pkg for the result item type.
module swd_hte_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  swd_hte_pkg::result_t  res_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output swd_hte_pkg::result_t  res_o
);

  logic                 valid_q, valid_d;
  swd_hte_pkg::result_t res_q;
  logic                 load;

  // A new item is taken whenever the register is empty or drains this cycle.
  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

### sv/swd_host_transaction_engine.sv
// Top level of the serial wire debug host transaction engine.
// Depends on swd_hte_pkg, swd_hte_core and swd_hte_out_stage.

// This block is a serial wire debug host sequencer driven one item at a time.
// A command item (read, write or line reset) arms a transaction when the
// engine is idle and is ignored while one runs; each tick item then stands for
// one clock pulse on the debug port, and its result gives the drive enable and
// level for that pulse, whether a pulse was issued, the busy and done flags,
// the ack captured so far and the data and raw parity of the last finished
// read. A read takes 48 ticks, a write 66 and a line reset 63. Sampled line
// levels must be supplied with the tick that samples them. One item is taken
// per clock cycle unless the output stalls, and its result shows in the next
// cycle: the sequencer state and the result register both update at the edge
// that accepts an item; while full, the register takes a new one only as the
// old one leaves. No configuration and no clearing pass after reset.
module swd_host_transaction_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic        ap_sel_i,
  input  logic [1:0]  reg_addr_i,
  input  logic [31:0] write_data_i,
  input  logic        line_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        drive_enable_o,
  output logic        drive_level_o,
  output logic        clock_pulse_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [2:0]  ack_o,
  output logic [31:0] read_data_o,
  output logic        read_parity_o
);

  swd_hte_pkg::result_t res_d, res_q;
  logic                 fire;

  // The sequencer advances exactly when an input item is accepted.
  assign fire = in_valid_i && in_ready_o;

  swd_hte_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .kind_i       (kind_i),
    .ap_sel_i     (ap_sel_i),
    .reg_addr_i   (reg_addr_i),
    .write_data_i (write_data_i),
    .line_in_i    (line_in_i),
    .res_o        (res_d)
  );

  swd_hte_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .res_i       (res_d),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_q)
  );

  assign drive_enable_o = res_q.drive_enable;
  assign drive_level_o  = res_q.drive_level;
  assign clock_pulse_o  = res_q.clock_pulse;
  assign busy_res_o     = res_q.busy_res;
  assign done_res_o     = res_q.done_res;
  assign ack_o          = res_q.ack;
  assign read_data_o    = res_q.read_data;
  assign read_parity_o  = res_q.read_parity;

  // A finishing tick always issues a pulse and leaves the engine idle.
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> clock_pulse_o && !busy_res_o)
    else $error("done result without pulse or with busy still set");

  // A released line is never shown as driven high.
  a_release_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !drive_enable_o |-> !drive_level_o)
    else $error("drive level high while line released");

  // A released line only occurs on a pulse of a running transaction.
  a_release_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !drive_enable_o |-> clock_pulse_o)
    else $error("line released without a clock pulse");

  // A command item never issues a pulse.
  a_cmd_no_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && kind_i != swd_hte_pkg::KIND_TICK |=> !clock_pulse_o)
    else $error("command item issued a clock pulse");

endmodule
